// ===== rtl/direct_mapped_tsb_table_macros.svh =====
// assertion helpers, compiled out for synthesis
`ifndef DIRECT_MAPPED_TSB_TABLE_MACROS_SVH
`define DIRECT_MAPPED_TSB_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define DMTSB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DMTSB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DMTSB_ASSERT(lbl, clk, rst_n, prop, msg)
`define DMTSB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/dmtsb_pkg.sv =====
`timescale 1ns / 1ps

package dmtsb_pkg;

    localparam int TABLE_ENTRIES = 512;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int VA_W          = 64;
    localparam int PA_W          = 41;
    localparam int PAGE_SHIFT    = 13;
    localparam int TAG_SHIFT     = 22;
    localparam int TAG_W         = VA_W - TAG_SHIFT;
    localparam int PPN_W         = PA_W - PAGE_SHIFT;
    localparam int FLAG_W        = 7;
    localparam int PAY_W         = PPN_W + FLAG_W;
    localparam int DATA_W        = 64;
    localparam int CNT_W         = 32;
    localparam int HI_PAD_W      = DATA_W - 1 - PAGE_SHIFT - PPN_W;
    localparam int LO_PAD_W      = PAGE_SHIFT - FLAG_W;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } t_opcode;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } t_state;

    typedef struct packed {
        t_opcode             opcode;
        logic [VA_W-1:0]     vaddr;
        logic [PA_W-1:0]     physical_address;
        logic [FLAG_W-1:0]   attribute_flags;
    } t_in_word;

    typedef struct packed {
        logic                hit;
        logic [DATA_W-1:0]   entry_data;
        logic                replaced_valid;
        logic [CNT_W-1:0]    collision_total;
    } t_out_word;

    typedef struct packed {
        logic                valid;
        logic [TAG_W-1:0]    tag;
        logic [PAY_W-1:0]    payload;
    } t_entry;

endpackage

// ===== rtl/direct_mapped_tsb_table.sv =====
`timescale 1ns / 1ps
`include "direct_mapped_tsb_table_macros.svh"
// direct-mapped translation table for 8 KB pages
//
// command channel: a word is taken at a rising edge with start high and busy
// low. opcode selects insert or lookup. the table is indexed by virtual
// address bits starting at 13 and tagged with bits 63:22.
// result channel: o_strobe is high for one cycle with the result word on
// o_out_word; the receiver cannot stall, so every result is taken then.
// config: i_cfg_we writes i_cfg_wdata into the table enable bit; the user must
// write it only while no command is in flight, which the block does not enforce.
// timing: one command per cycle while busy is low. the entry store has one read
// and one write port with a registered read; a command is registered into
// r_s1 and r_rd_data, then its result into o_out_word together with the strobe.
// an insert followed at once by an access to the same slot is forwarded
// around the memory.
// reset: the table enable and collision count clear, then a clearing pass
// writes every entry of the store, one per cycle, during which busy stays
// high; config writes are still taken then.
module direct_mapped_tsb_table (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  dmtsb_pkg::t_in_word  i_in_word,
    output logic                 o_strobe,
    output dmtsb_pkg::t_out_word o_out_word,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata
);
    import dmtsb_pkg::*;

    t_entry               r_mem [TABLE_ENTRIES];

    t_state               r_state;
    t_state               n_state;
    logic [IDX_W-1:0]     r_clr_addr;
    logic                 clr_active;

    logic                 r_enabled;
    logic                 r_s1_valid;
    t_in_word             r_s1;
    t_entry               r_rd_data;
    logic                 r_byp_hit;
    t_entry               r_byp_data;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_strobe;
    t_out_word            r_out;
    t_out_word            n_out;

    logic                 accept;
    logic [IDX_W-1:0]     in_slot;
    logic [IDX_W-1:0]     s1_slot;
    logic [TAG_W-1:0]     s1_tag;
    t_entry               cur;
    t_entry               ins_entry;
    logic                 do_ins;
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    t_entry               wdata;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == IDX_W'(TABLE_ENTRIES - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN:   n_state = ST_RUN;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        clr_active = 1'b0;
        case (r_state)
            ST_CLEAR: clr_active = 1'b1;
            ST_RUN:   clr_active = 1'b0;
            default:  clr_active = 1'b1;
        endcase
    end

    assign busy    = clr_active;
    assign accept  = start && !busy;
    assign in_slot = i_in_word.vaddr[PAGE_SHIFT +: IDX_W];
    assign s1_slot = r_s1.vaddr[PAGE_SHIFT +: IDX_W];
    assign s1_tag  = r_s1.vaddr[VA_W-1:TAG_SHIFT];
    assign cur     = r_byp_hit ? r_byp_data : r_rd_data;
    assign do_ins  = r_s1_valid && r_enabled && (r_s1.opcode == OP_INSERT);

    always_comb begin
        ins_entry.valid   = 1'b1;
        ins_entry.tag     = s1_tag;
        ins_entry.payload = {r_s1.physical_address[PA_W-1:PAGE_SHIFT],
                             r_s1.attribute_flags};
    end

    always_comb begin
        we    = do_ins;
        waddr = s1_slot;
        wdata = ins_entry;
        if (clr_active) begin
            we    = 1'b1;
            waddr = r_clr_addr;
            wdata = '0;
        end
    end

    always_comb begin
        n_count = r_count;
        n_out   = '0;
        if (do_ins && cur.valid) begin
            n_count              = r_count + CNT_W'(1);
            n_out.replaced_valid = 1'b1;
        end
        if (r_s1_valid && r_enabled && (r_s1.opcode == OP_LOOKUP)
            && cur.valid && (cur.tag == s1_tag)) begin
            n_out.hit        = 1'b1;
            n_out.entry_data = {1'b1, {HI_PAD_W{1'b0}}, cur.payload[PAY_W-1:FLAG_W],
                                {LO_PAD_W{1'b0}}, cur.payload[FLAG_W-1:1], 1'b1};
        end
        n_out.collision_total = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (accept) begin
            r_rd_data <= r_mem[in_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1       <= i_in_word;
        r_byp_data <= ins_entry;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_enabled  <= 1'b0;
            r_s1_valid <= 1'b0;
            r_byp_hit  <= 1'b0;
            r_count    <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            if (clr_active) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (i_cfg_we) begin
                r_enabled <= i_cfg_wdata;
            end
            r_s1_valid <= accept;
            r_byp_hit  <= accept && do_ins && (s1_slot == in_slot);
            r_count    <= n_count;
            r_strobe   <= r_s1_valid;
        end
    end

    assign o_strobe   = r_strobe;
    assign o_out_word = r_out;

    `DMTSB_ASSERT(a_accept_strobe, i_clk, i_rst_n, accept |=> ##1 r_strobe, "accepted word gave no result")
    `DMTSB_ASSERT(a_no_work_in_clear, i_clk, i_rst_n, clr_active |-> (!r_s1_valid && !accept), "command in flight during clearing pass")
    `DMTSB_ASSERT(a_count_step, i_clk, i_rst_n, (r_strobe && r_out.replaced_valid) |-> (r_out.collision_total == CNT_W'($past(r_count) + CNT_W'(1))), "collision count did not advance")
    `DMTSB_ASSERT(a_hit_xor_replace, i_clk, i_rst_n, r_strobe |-> !(r_out.hit && r_out.replaced_valid), "hit and replace in one result")
    `DMTSB_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> (busy && !r_strobe), "reset did not start clearing pass")

endmodule

// ===== tb/direct_mapped_tsb_table_tb.sv =====
`timescale 1ns / 1ps

module direct_mapped_tsb_table_tb;
    import dmtsb_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int POOL_SIZE   = 16;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_word  i_in_word;
    logic      o_strobe;
    t_out_word o_out_word;
    logic      i_cfg_we;
    logic      i_cfg_wdata;

    direct_mapped_tsb_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in_word   (i_in_word),
        .o_strobe    (o_strobe),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // shadow copy of the table
    logic             table_on;
    logic             slot_valid [TABLE_ENTRIES];
    logic [TAG_W-1:0] slot_tag   [TABLE_ENTRIES];
    logic [PAY_W-1:0] slot_pay   [TABLE_ENTRIES];
    logic [CNT_W-1:0] collisions;

    t_out_word   due_results[$];
    t_out_word   oldest_result;
    int unsigned error_count;
    int unsigned sent_count;
    int unsigned hit_count;
    int unsigned replace_count;
    int unsigned sender_idle_pct;
    logic [VA_W-1:0] va_pool [POOL_SIZE];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_out_word resolve_tsb_access(input t_in_word w);
        t_out_word        res;
        logic [IDX_W-1:0] slot;
        logic [TAG_W-1:0] tag;
        logic [PAY_W-1:0] pay;
        res  = '0;
        slot = w.vaddr[PAGE_SHIFT +: IDX_W];
        tag  = w.vaddr[VA_W-1:TAG_SHIFT];
        if (table_on) begin
            if (w.opcode == OP_INSERT) begin
                if (slot_valid[slot]) begin
                    res.replaced_valid = 1'b1;
                    collisions = collisions + 1'b1;
                end
                slot_valid[slot] = 1'b1;
                slot_tag[slot]   = tag;
                slot_pay[slot]   = {w.physical_address[PA_W-1:PAGE_SHIFT], w.attribute_flags};
            end else if (slot_valid[slot] && slot_tag[slot] == tag) begin
                pay = slot_pay[slot];
                res.hit = 1'b1;
                res.entry_data[DATA_W-1]              = 1'b1;
                res.entry_data[PAGE_SHIFT +: PPN_W]   = pay[PAY_W-1:FLAG_W];
                res.entry_data[FLAG_W-1:0]            = pay[FLAG_W-1:0];
                res.entry_data[0]                     = 1'b1;
            end
        end
        res.collision_total = collisions;
        if (res.hit) hit_count++;
        if (res.replaced_valid) replace_count++;
        return res;
    endfunction

    function automatic t_in_word make_word(input t_opcode op, input logic [VA_W-1:0] va,
                                           input logic [PA_W-1:0] pa,
                                           input logic [FLAG_W-1:0] flags);
        t_in_word w;
        w.opcode           = op;
        w.vaddr            = va;
        w.physical_address = pa;
        w.attribute_flags  = flags;
        return w;
    endfunction

    function automatic logic [PA_W-1:0] random_pa();
        return PA_W'({$urandom, $urandom});
    endfunction

    function automatic t_opcode random_op();
        return ($urandom_range(1) != 0) ? OP_LOOKUP : OP_INSERT;
    endfunction

    task automatic send_word(input t_in_word w);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start     = 1'b1;
        i_in_word = w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        due_results.push_back(resolve_tsb_access(w));
        sent_count++;
    endtask

    task automatic stop_and_drain();
        @(negedge i_clk);
        start = 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_table_enable(input logic value);
        stop_and_drain();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        table_on    = value;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (due_results.size() == 0) begin
                $error("result word with nothing expected: %h", o_out_word);
                error_count++;
            end else begin
                oldest_result = due_results.pop_front();
                if (o_out_word.hit !== oldest_result.hit) begin
                    $error("hit: expected %0b, got %0b", oldest_result.hit, o_out_word.hit);
                    error_count++;
                end
                if (o_out_word.entry_data !== oldest_result.entry_data) begin
                    $error("entry_data: expected %h, got %h",
                           oldest_result.entry_data, o_out_word.entry_data);
                    error_count++;
                end
                if (o_out_word.replaced_valid !== oldest_result.replaced_valid) begin
                    $error("replaced_valid: expected %0b, got %0b",
                           oldest_result.replaced_valid, o_out_word.replaced_valid);
                    error_count++;
                end
                if (o_out_word.collision_total !== oldest_result.collision_total) begin
                    $error("collision_total: expected %0d, got %0d",
                           oldest_result.collision_total, o_out_word.collision_total);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_strobe) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("timeout after %0d quiet cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    task automatic test_disabled_table();
        write_table_enable(1'b0);
        send_word(make_word(OP_INSERT, 64'h0000_0000_0040_2000, random_pa(), 7'h3C));
        send_word(make_word(OP_LOOKUP, 64'h0000_0000_0040_2000, '0, '0));
        write_table_enable(1'b1);
    endtask

    task automatic test_basic_translation();
        send_word(make_word(OP_LOOKUP, '0, '0, '0));
        send_word(make_word(OP_INSERT, '0, '0, '0));
        send_word(make_word(OP_LOOKUP, '0, '0, '0));
        send_word(make_word(OP_INSERT, '1, '1, '1));
        send_word(make_word(OP_LOOKUP, '1, '0, '0));
        send_word(make_word(OP_LOOKUP, {42'h0, 9'h1FF, 13'h0}, '1, '1));
    endtask

    task automatic test_slot_collision();
        send_word(make_word(OP_INSERT, {42'h0, 9'h1FF, 13'h1FFF}, random_pa(), 7'h54));
        send_word(make_word(OP_LOOKUP, '1, '0, '0));
        send_word(make_word(OP_LOOKUP, {42'h0, 9'h1FF, 13'h0}, '0, '0));
        // insert then lookup on one slot, back-to-back when the sender does not idle
        send_word(make_word(OP_INSERT, {42'h1, 9'h0, 13'h0}, random_pa(), 7'h2A));
        send_word(make_word(OP_LOOKUP, {42'h1, 9'h0, 13'h1234}, '0, '0));
        send_word(make_word(OP_LOOKUP, '0, '0, '0));
    endtask

    task automatic test_table_toggle();
        write_table_enable(1'b0);
        send_word(make_word(OP_INSERT, {42'h2, 9'h0, 13'h0}, '1, '1));
        send_word(make_word(OP_LOOKUP, {42'h1, 9'h0, 13'h0}, '0, '0));
        write_table_enable(1'b1);
        send_word(make_word(OP_LOOKUP, {42'h1, 9'h0, 13'h0}, '0, '0));
    endtask

    task automatic fill_va_pool();
        logic [IDX_W-1:0] slots [4];
        logic [VA_W-1:0]  va;
        for (int i = 0; i < 4; i++) slots[i] = IDX_W'($urandom);
        for (int i = 0; i < POOL_SIZE; i++) begin
            va = {$urandom, $urandom};
            va[PAGE_SHIFT +: IDX_W] = slots[i % 4];
            va_pool[i] = va;
        end
    endtask

    function automatic logic [VA_W-1:0] pool_va();
        logic [VA_W-1:0] va;
        va = va_pool[$urandom_range(POOL_SIZE - 1)];
        va[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
        return va;
    endfunction

    task automatic run_random_traffic(input int unsigned n_items);
        int unsigned     sent;
        int unsigned     pick;
        logic [VA_W-1:0] va;
        sent = 0;
        fill_va_pool();
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                va = pool_va();
                send_word(make_word(OP_INSERT, va, random_pa(), FLAG_W'($urandom)));
                va[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
                send_word(make_word(OP_LOOKUP, va, random_pa(), FLAG_W'($urandom)));
                sent += 2;
            end else if (pick < 80) begin
                send_word(make_word(random_op(), pool_va(), random_pa(), FLAG_W'($urandom)));
                sent++;
            end else begin
                send_word(make_word(random_op(), {$urandom, $urandom}, random_pa(),
                                    FLAG_W'($urandom)));
                sent++;
            end
        end
    endtask

    task automatic test_disabled_noise();
        write_table_enable(1'b0);
        for (int i = 0; i < 12; i++) begin
            send_word(make_word(random_op(), pool_va(), random_pa(), FLAG_W'($urandom)));
        end
        write_table_enable(1'b1);
    endtask

    initial begin
        start           = 1'b0;
        i_in_word       = '0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = 1'b0;
        i_rst_n         = 1'b0;
        table_on        = 1'b0;
        collisions      = '0;
        error_count     = 0;
        sent_count      = 0;
        hit_count       = 0;
        replace_count   = 0;
        sender_idle_pct = 16;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
            slot_tag[i]   = '0;
            slot_pay[i]   = '0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_disabled_table();
        test_basic_translation();
        test_slot_collision();
        test_table_toggle();

        run_random_traffic(180);
        test_disabled_noise();
        sender_idle_pct = 47;
        run_random_traffic(180);
        sender_idle_pct = 0;
        run_random_traffic(175);

        stop_and_drain();
        repeat (8) @(posedge i_clk);

        $display("sent %0d table operations: %0d lookup hits, %0d slot replacements",
                 sent_count, hit_count, replace_count);
        $display("final collision count %0d, %0d mismatches", collisions, error_count);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
